// File: design/assert_macros.svh
// Assertion helpers for the checker file tsi_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define TSI_ASSERT_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, with a generic message.
`define TSI_ASSERT(label, clk, rst_n, prop) \
  `TSI_ASSERT_MSG(label, clk, rst_n, prop, "tsi assertion failed")

`endif

// File: design/tsi_pkg.sv
// ----------------------------------------------------------------------------
// tsi_pkg
// Types and constants of the timestamp sync interpolator.
// ----------------------------------------------------------------------------
package tsi_pkg;

  localparam int unsigned TDATA_W    = 240;
  localparam int unsigned NUM_FIELDS = 6;
  localparam int unsigned DIV_STEPS  = 58;
  localparam logic [23:0] MAX_GAP_RST = 24'd200000;
  localparam logic        REQ_PUSH  = 1'b0;
  localparam logic        REQ_QUERY = 1'b1;

  typedef struct packed {
    logic [47:0]        stamp;
    logic [7:0]         status;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [31:0] alt;
    logic signed [31:0] east;
    logic signed [31:0] north;
    logic signed [31:0] up;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_CHECK, ST_MUL0, ST_MUL1, ST_PREP, ST_DIV, ST_STORE,
    ST_DONE_OK, ST_DONE_FAIL
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd;
    logic pop;
    logic wcalc;
    logic mul0;
    logic mul1;
    logic prep;
    logic div_step;
    logic store;
    logic emit_ok;
    logic emit_fail;
  } cmd_t;

  typedef struct packed {
    logic cnt_ge2;
    logic t0_gt_q;
    logic t1_lt_q;
    logic bad_gap;
    logic div_done;
    logic last_field;
    logic out_free;
  } sts_t;

  function automatic logic signed [31:0] field_of(entry_t e, logic [2:0] idx);
    logic signed [31:0] v;
    case (idx)
      3'd0:    v = e.lat;
      3'd1:    v = e.lon;
      3'd2:    v = e.alt;
      3'd3:    v = e.east;
      3'd4:    v = e.north;
      default: v = e.up;
    endcase
    return v;
  endfunction

endpackage

// File: design/tsi_ctrl.sv
// ----------------------------------------------------------------------------
// tsi_ctrl
// Sequencer: bracket walk, per-field multiply and serial divide, result hand-off.
// ----------------------------------------------------------------------------
module tsi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_query_i,
  output logic          in_ready_o,
  input  tsi_pkg::sts_t sts_i,
  output tsi_pkg::cmd_t cmd_o
);
  import tsi_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_query_i == REQ_QUERY) state_d = ST_READ;
      end
      ST_READ:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (!sts_i.cnt_ge2 || sts_i.t0_gt_q) state_d = ST_DONE_FAIL;
        else if (sts_i.t1_lt_q)              state_d = ST_READ;
        else if (sts_i.bad_gap)              state_d = ST_DONE_FAIL;
        else                                 state_d = ST_MUL0;
      end
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_STORE;
      end
      ST_STORE: state_d = sts_i.last_field ? ST_DONE_OK : ST_MUL0;
      ST_DONE_OK, ST_DONE_FAIL: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = in_valid_i;
      end
      ST_READ:  cmd_o.rd = 1'b1;
      ST_CHECK: begin
        if (sts_i.cnt_ge2 && !sts_i.t0_gt_q) begin
          // drop a stale or unusable head
          cmd_o.pop   = sts_i.t1_lt_q || sts_i.bad_gap;
          cmd_o.wcalc = !sts_i.t1_lt_q && !sts_i.bad_gap;
        end
      end
      ST_MUL0:      cmd_o.mul0      = 1'b1;
      ST_MUL1:      cmd_o.mul1      = 1'b1;
      ST_PREP:      cmd_o.prep      = 1'b1;
      ST_DIV:       cmd_o.div_step  = 1'b1;
      ST_STORE:     cmd_o.store     = 1'b1;
      ST_DONE_OK:   cmd_o.emit_ok   = sts_i.out_free;
      ST_DONE_FAIL: cmd_o.emit_fail = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// File: design/tsi_dp.sv
// ----------------------------------------------------------------------------
// tsi_dp
// Sample FIFO, bracket compare, multiply-accumulate, restoring divider and
// output register.
// ----------------------------------------------------------------------------
module tsi_dp #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tsi_pkg::cmd_t                cmd_i,
  output tsi_pkg::sts_t                sts_o,
  input  logic                         cfg_we_i,
  input  logic [23:0]                  cfg_wdata_i,
  input  logic                         in_req_i,
  input  logic [tsi_pkg::TDATA_W-1:0]  in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         out_ok_o,
  output logic [tsi_pkg::TDATA_W-1:0]  out_data_o
);
  import tsi_pkg::*;

  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  entry_t             mem [FIFO_DEPTH];
  entry_t             rd0_q, rd1_q, wentry;
  logic [PW-1:0]      head_q, head_nx, waddr;
  logic [CW-1:0]      cnt_q;
  logic [SW-1:0]      tail_sum, tail;
  logic               full;
  logic [23:0]        max_gap_q;
  logic [47:0]        q_q, w0_full, w1_full;
  logic [23:0]        w0_q, w1_q;
  logic [24:0]        d_q;
  logic [2:0]         fidx_q;
  logic signed [56:0] p0_q, p1_q;
  logic signed [57:0] num;
  logic [57:0]        mag, n_q;
  logic               neg_q;
  logic [26:0]        rem_q, shift, dsor;
  logic               ge;
  logic [5:0]         dcnt_q;
  logic [31:0]        res_q [NUM_FIELDS];
  logic [31:0]        qval;
  logic               out_valid_q, out_ok_q;
  logic [TDATA_W-1:0] out_data_q;

  assign full     = cnt_q == CW'(FIFO_DEPTH);
  assign head_nx  = (head_q == PW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_sum = SW'(head_q) + SW'(cnt_q);
  assign tail     = (tail_sum >= SW'(FIFO_DEPTH)) ? tail_sum - SW'(FIFO_DEPTH) : tail_sum;
  assign waddr    = full ? head_q : tail[PW-1:0];

  always_comb begin
    wentry.stamp  = in_data_i[47:0];
    wentry.status = in_data_i[55:48];
    wentry.lat    = {in_data_i[86], in_data_i[86:56]};
    wentry.lon    = in_data_i[118:87];
    wentry.alt    = {{7{in_data_i[143]}}, in_data_i[143:119]};
    wentry.east   = in_data_i[175:144];
    wentry.north  = in_data_i[207:176];
    wentry.up     = in_data_i[239:208];
  end

  // sample store, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_req_i == REQ_PUSH) mem[waddr] <= wentry;
    if (cmd_i.rd) begin
      rd0_q <= mem[head_q];
      rd1_q <= mem[head_nx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      cnt_q     <= '0;
      max_gap_q <= MAX_GAP_RST;
    end else begin
      if (cfg_we_i) max_gap_q <= cfg_wdata_i;
      if (cmd_i.accept && in_req_i == REQ_PUSH) begin
        if (full) head_q <= head_nx;   // drop oldest
        else      cnt_q  <= cnt_q + 1'b1;
      end else if (cmd_i.pop) begin
        head_q <= head_nx;
        cnt_q  <= cnt_q - 1'b1;
      end
    end
  end

  assign w1_full = q_q - rd0_q.stamp;
  assign w0_full = rd1_q.stamp - q_q;

  assign sts_o.cnt_ge2    = cnt_q >= CW'(2);
  assign sts_o.t0_gt_q    = rd0_q.stamp > q_q;
  assign sts_o.t1_lt_q    = rd1_q.stamp < q_q;
  assign sts_o.bad_gap    = (w1_full > {24'd0, max_gap_q}) || (w0_full > {24'd0, max_gap_q})
                          || (rd1_q.stamp == rd0_q.stamp);
  assign sts_o.div_done   = dcnt_q == 6'(DIV_STEPS - 1);
  assign sts_o.last_field = fidx_q == 3'(NUM_FIELDS - 1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign num   = {p0_q[56], p0_q} + {p1_q[56], p1_q};
  assign mag   = num[57] ? 58'(-num) : 58'(num);
  assign dsor  = {1'b0, d_q, 1'b0};
  assign shift = {rem_q[25:0], n_q[57]};
  assign ge    = shift >= dsor;
  assign qval  = neg_q ? -n_q[31:0] : n_q[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) q_q <= in_data_i[47:0];
    if (cmd_i.wcalc) begin
      w0_q   <= w0_full[23:0];
      w1_q   <= w1_full[23:0];
      d_q    <= {1'b0, w0_full[23:0]} + {1'b0, w1_full[23:0]};
      fidx_q <= '0;
    end
    if (cmd_i.mul0) p0_q <= field_of(rd0_q, fidx_q) * $signed({1'b0, w0_q});
    if (cmd_i.mul1) p1_q <= field_of(rd1_q, fidx_q) * $signed({1'b0, w1_q});
    if (cmd_i.prep) begin
      // round half away from zero: (2|num| + d) / 2d
      neg_q  <= num[57];
      n_q    <= {mag[56:0], 1'b0} + {33'd0, d_q};
      rem_q  <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? shift - dsor : shift;
      n_q    <= {n_q[56:0], ge};
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.store) begin
      res_q[fidx_q] <= qval;
      fidx_q        <= fidx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_ok || cmd_i.emit_fail) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ok) begin
      out_ok_q   <= 1'b1;
      out_data_q <= {res_q[5], res_q[4], res_q[3], res_q[2][24:0], res_q[1],
                     res_q[0][30:0], rd1_q.status, q_q};
    end else if (cmd_i.emit_fail) begin
      out_ok_q   <= 1'b0;
      out_data_q <= {192'd0, q_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ok_o    = out_ok_q;
  assign out_data_o  = out_data_q;

endmodule

// File: design/timestamp_sync_interpolator.sv
// ----------------------------------------------------------------------------
// timestamp_sync_interpolator
// Position sample FIFO with linear interpolation at a queried timestamp.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tuser 0 pushes a sample, 1 asks for a sync at the
// time in tdata. A push gives no result and leaves the block idle and ready.
// A query reads the pair at the FIFO head and checks it, dropping a stale
// head and reading again, then runs six fields in turn through a weighted
// multiply of each sample, a rounding step and a one-bit-per-cycle restoring
// divider of 58 steps; the serial divider takes most of a successful query's
// time. One result per query leaves on the output stream with tuser = sync_ok.
// The result waits in an output register while m_axis_tready is low; pushes
// are still taken then unless a query is running, and a further query
// finishes its work and waits for it. Reset empties the FIFO and sets max_gap
// to 200000; stored samples need no clearing. The user must write max_gap
// via cfg_we_i only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module timestamp_sync_interpolator #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // item_time, fix_status, lat_in, lon_in, alt_in, east_in, north_in, up_in
  input  logic [239:0] s_axis_tdata,
  // req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_time, out_status, lat_out, lon_out, alt_out, east_out, north_out, up_out
  output logic [239:0] m_axis_tdata,
  // sync_ok
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [23:0]  cfg_wdata_i
);
  import tsi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_query_i (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tsi_dp #(.FIFO_DEPTH(FIFO_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ok_o    (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: design/tsi_check.sv
// ----------------------------------------------------------------------------
// tsi_check
// Port-level checks of the timestamp sync interpolator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsi_check (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [239:0] s_axis_tdata,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [239:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // held result keeps its payload
  `TSI_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // failed query carries only its time
  `TSI_ASSERT(a_fail_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[239:48] == 192'd0)
  // a query occupies the block
  `TSI_ASSERT(a_query_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
  // a push never blocks the input
  `TSI_ASSERT(a_push_free, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)

endmodule

bind timestamp_sync_interpolator tsi_check u_tsi_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
